// ===== hdl/polyphase_fir_interpolator_q15_top_assert.svh =====
// Assertion macros used by the interpolator engine.
`ifndef POLYPHASE_FIR_INTERPOLATOR_Q15_TOP_ASSERT_SVH
`define POLYPHASE_FIR_INTERPOLATOR_Q15_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFI_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFI_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/pfi_pkg.sv =====
// Types, constants and codes shared by the polyphase interpolator modules.
package pfi_pkg;

   localparam int MAX_TAPS   = 256;
   localparam int MAX_PHASE  = 64;
   localparam int MAX_FACTOR = 16;

   localparam int COEF_AW      = $clog2(MAX_TAPS);
   localparam int DLY_AW       = $clog2(MAX_PHASE);
   localparam int FACTOR_IDX_W = $clog2(MAX_FACTOR);

   localparam int FACTOR_W = 5;
   localparam int PHASE_W  = 7;
   localparam int DATA_W   = 16;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int ACC_W    = PROD_W + DLY_AW;
   localparam int Q_SHIFT  = 15;
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   localparam int CSR_AW = 1;
   localparam int CSR_DW = 7;
   localparam logic [CSR_AW-1:0] CSR_INTERP_FACTOR = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_PHASE_LENGTH  = 1'b1;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] sample_in;
      logic [7:0]               coef_index;
      logic signed [DATA_W-1:0] coef_value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample_out;
      logic                     is_last;
   } rsp_item_type;

   typedef enum logic {
      CMD_SAMPLE,
      CMD_COEF
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic signed [DATA_W-1:0] value;
      logic [COEF_AW-1:0]       addr;
   } cmd_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] factor;
      logic [PHASE_W-1:0]  taps;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_MAC,
      ST_DRAIN
   } engine_state_type;

endpackage

// ===== hdl/pfi_front.sv =====
// Request front end: accepts requests, classifies them and queues commands.
module pfi_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  pfi_pkg::req_item_type req_item,
   output logic                 cmd_valid,
   output pfi_pkg::cmd_type     cmd,
   input  logic                 cmd_pop
);
   import pfi_pkg::*;

   localparam int QAW   = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type          queue_ff [CMD_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          cmd_new;
   logic             accept;
   logic             take;

   always_comb begin
      cmd_new.addr = req_item.coef_index[COEF_AW-1:0];
      if (req_item.req_type) begin
         cmd_new.kind  = CMD_COEF;
         cmd_new.value = req_item.coef_value;
      end else begin
         cmd_new.kind  = CMD_SAMPLE;
         cmd_new.value = req_item.sample_in;
      end
   end

   assign full      = (count_ff == CNT_W'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign accept    = push && !full;
   assign take      = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(accept) - CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ===== hdl/pfi_engine.sv =====
// Execution engine: coefficient and delay memories and the shared multiply-accumulate.
`include "polyphase_fir_interpolator_q15_top_assert.svh"

module pfi_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  pfi_pkg::cfg_type      cfg,
   input  logic                  cmd_valid,
   input  pfi_pkg::cmd_type      cmd,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output pfi_pkg::rsp_item_type rsp_item
);
   import pfi_pkg::*;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

   engine_state_type          state_ff, state_in;
   logic [FACTOR_W-1:0]       factor_ff, factor_in;
   logic [PHASE_W-1:0]        taps_ff, taps_in;
   logic [FACTOR_IDX_W-1:0]   phase_ff, phase_in;
   logic [DLY_AW-1:0]         wp_ff, wp_in;
   logic [DLY_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [DLY_AW-1:0]         k_ff, k_in;
   logic [COEF_AW-1:0]        ci_ff, ci_in;

   logic                      dly_we;
   logic                      coef_we;
   logic                      issue;
   logic                      acc_clr;
   logic                      rd_v_ff;
   logic                      mul_v_ff;

   logic signed [DATA_W-1:0]  dly_mem_ff  [MAX_PHASE];
   logic signed [DATA_W-1:0]  coef_mem_ff [MAX_TAPS];
   logic [MAX_PHASE-1:0]      dly_vld_ff;
   logic signed [DATA_W-1:0]  dly_rd_ff;
   logic                      dly_rd_vld_ff;
   logic signed [DATA_W-1:0]  coef_rd_ff;
   logic signed [DATA_W-1:0]  dly_opd;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_shr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wp_ff     <= '0;
         rd_v_ff   <= 1'b0;
         mul_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         rd_v_ff   <= issue;
         mul_v_ff  <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      factor_ff <= factor_in;
      taps_ff   <= taps_in;
      phase_ff  <= phase_in;
      rd_ptr_ff <= rd_ptr_in;
      k_ff      <= k_in;
      ci_ff     <= ci_in;
   end

   always_comb begin
      state_in  = state_ff;
      factor_in = factor_ff;
      taps_in   = taps_ff;
      phase_in  = phase_ff;
      wp_in     = wp_ff;
      rd_ptr_in = rd_ptr_ff;
      k_in      = k_ff;
      ci_in     = ci_ff;
      cmd_pop   = 1'b0;
      dly_we    = 1'b0;
      coef_we   = 1'b0;
      issue     = 1'b0;
      acc_clr   = 1'b0;
      rsp_push  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.kind == CMD_COEF) begin
                  coef_we = 1'b1;
               end else begin
                  dly_we    = 1'b1;
                  wp_in     = wp_ff + DLY_AW'(1);
                  factor_in = cfg.factor;
                  taps_in   = cfg.taps;
                  phase_in  = FACTOR_IDX_W'(cfg.factor - FACTOR_W'(1));
                  state_in  = ST_START;
               end
            end
         end
         ST_START: begin
            // A phase only starts when its result is sure to find room.
            if (!rsp_full) begin
               acc_clr   = 1'b1;
               k_in      = '0;
               ci_in     = COEF_AW'(phase_ff);
               rd_ptr_in = wp_ff - taps_ff[DLY_AW-1:0];
               state_in  = ST_MAC;
            end
         end
         ST_MAC: begin
            issue     = 1'b1;
            rd_ptr_in = rd_ptr_ff + DLY_AW'(1);
            ci_in     = ci_ff + COEF_AW'(factor_ff);
            k_in      = k_ff + DLY_AW'(1);
            if (k_ff == DLY_AW'(taps_ff - PHASE_W'(1))) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !mul_v_ff) begin
               rsp_push = 1'b1;
               if (phase_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  phase_in = phase_ff - FACTOR_IDX_W'(1);
                  state_in = ST_START;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The delay line is a ring; a slot never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         dly_vld_ff <= '0;
      end else if (dly_we) begin
         dly_vld_ff[wp_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem_ff[wp_ff] <= cmd.value;
      end
      dly_rd_ff     <= dly_mem_ff[rd_ptr_ff];
      dly_rd_vld_ff <= dly_vld_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem_ff[cmd.addr] <= cmd.value;
      end
      coef_rd_ff <= coef_mem_ff[ci_ff];
   end

   assign dly_opd = dly_rd_vld_ff ? dly_rd_ff : 16'sd0;

   always_ff @(posedge clock) begin
      prod_ff <= dly_opd * coef_rd_ff;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (mul_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign acc_shr = acc_ff >>> Q_SHIFT;

   always_comb begin
      if (acc_shr > SAT_HI) begin
         rsp_item.sample_out = DATA_W'(SAT_HI);
      end else if (acc_shr < SAT_LO) begin
         rsp_item.sample_out = DATA_W'(SAT_LO);
      end else begin
         rsp_item.sample_out = acc_shr[DATA_W-1:0];
      end
      rsp_item.is_last = (phase_ff == '0);
   end

   `PFI_ASSERT_IMPLY(a_push_room, clock, reset, rsp_push, !rsp_full, "result pushed into a full queue")
   `PFI_ASSERT_IMPLY(a_pop_idle, clock, reset, cmd_pop, state_ff == ST_IDLE, "command taken while busy")
   `PFI_ASSERT_NEXT(a_issue_read, clock, reset, state_ff == ST_MAC, rd_v_ff, "tap read not in flight")
   `PFI_ASSERT_IMPLY(a_push_drained, clock, reset, rsp_push, !rd_v_ff && !mul_v_ff, "result taken before the pipeline drained")

endmodule

// ===== hdl/pfi_rsp_fifo.sv =====
// Result queue between the engine and the result channel.
module pfi_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_push,
   input  pfi_pkg::rsp_item_type wr_item,
   output logic                  wr_full,
   output logic                  empty,
   input  logic                  pop,
   output pfi_pkg::rsp_item_type rsp_item
);
   import pfi_pkg::*;

   localparam int QAW   = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   rsp_item_type     queue_ff [RSP_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             put;
   logic             take;

   assign wr_full  = (count_ff == CNT_W'(RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_item = queue_ff[rd_ptr_ff];
   assign put      = wr_push && !wr_full;
   assign take     = pop && !empty;

   always_comb begin
      wr_ptr_in = put ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(put) - CNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         queue_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ===== hdl/polyphase_fir_interpolator_q15_top.sv =====
// Polyphase Q15 FIR interpolator: request queue, engine, result queue and registers.
//
// A coefficient request writes one entry of the 256-deep coefficient memory without
// the engine leaving idle. A sample request shifts the sample into the 64-deep delay
// line and yields interp_factor results, phase factor-1 first, the last flagged by
// is_last. The single multiply-accumulate unit takes one tap per cycle, and each
// phase adds a set-up state before its taps and a drain through memory read,
// product and accumulate. A two-entry request queue lets requests arrive while the
// engine works, and a four-entry result queue holds results until they are popped;
// the engine waits before a phase while that queue is full. The delay line reads as
// zero after reset; coefficients hold no defined value until written. The user must
// write the registers only while the block is idle; the block does not enforce it.
module polyphase_fir_interpolator_q15_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  pfi_pkg::req_item_type       req_item,
   output logic                        empty,
   input  logic                        pop,
   output pfi_pkg::rsp_item_type       rsp_item,
   input  logic                        csr_write_en,
   input  logic [pfi_pkg::CSR_AW-1:0]  csr_index,
   input  logic [pfi_pkg::CSR_DW-1:0]  csr_wdata
);
   import pfi_pkg::*;

   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [PHASE_W-1:0]  phase_len_ff, phase_len_in;
   cfg_type             cfg;
   logic                cmd_valid;
   cmd_type             cmd;
   logic                cmd_pop;
   logic                rsp_full;
   logic                rsp_push;
   rsp_item_type        eng_item;

   always_comb begin
      factor_in    = factor_ff;
      phase_len_in = phase_len_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_INTERP_FACTOR: factor_in    = csr_wdata[FACTOR_W-1:0];
            CSR_PHASE_LENGTH:  phase_len_in = csr_wdata[PHASE_W-1:0];
            default: begin
               factor_in    = factor_ff;
               phase_len_in = phase_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= FACTOR_W'(1);
         phase_len_ff <= PHASE_W'(1);
      end else begin
         factor_ff    <= factor_in;
         phase_len_ff <= phase_len_in;
      end
   end

   // Zero acts as one and values beyond the maximum saturate.
   always_comb begin
      if (factor_ff == '0) begin
         cfg.factor = FACTOR_W'(1);
      end else if (factor_ff > FACTOR_W'(MAX_FACTOR)) begin
         cfg.factor = FACTOR_W'(MAX_FACTOR);
      end else begin
         cfg.factor = factor_ff;
      end
      if (phase_len_ff == '0) begin
         cfg.taps = PHASE_W'(1);
      end else if (phase_len_ff > PHASE_W'(MAX_PHASE)) begin
         cfg.taps = PHASE_W'(MAX_PHASE);
      end else begin
         cfg.taps = phase_len_ff;
      end
   end

   pfi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   pfi_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (eng_item)
   );

   pfi_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (rsp_push),
      .wr_item  (eng_item),
      .wr_full  (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
